// ===== sv/srarq_pkg.sv =====
`default_nettype none

package srarq_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam bit WIN_POW2 = (WINDOW_DEPTH == (1 << IDX_W));

	localparam int SEQ_W = 32;
	localparam int TAG_W = 16;
	localparam int LEN_W = 11;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_RR      = 2'd1,
		KIND_SREJ    = 2'd2,
		KIND_EOFACK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SRC_PKT  = 2'd0,
		SRC_SLOT = 2'd1,
		SRC_EXP  = 2'd2,
		SRC_ZERO = 2'd3
	} src_t;

	typedef struct packed {
		logic             action;
		logic [SEQ_W-1:0] seq_num;
		logic [TAG_W-1:0] payload_tag;
		logic [LEN_W-1:0] payload_length;
	} pkt_t;

	typedef struct packed {
		kind_t            msg_kind;
		logic [SEQ_W-1:0] seq_value;
		logic [TAG_W-1:0] out_tag;
		logic [LEN_W-1:0] out_length;
		logic             last;
	} msg_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} slot_t;

	typedef struct packed {
		logic  load;
		logic  mod_start;
		logic  hold;
		logic  raise_high;
		logic  set_pend;
		logic  fin_pend;
		logic  inorder;
		logic  walk_start;
		logic  rd;
		logic  step;
		logic  emit;
		kind_t kind;
		src_t  src;
		logic  last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_eof;
		logic eof_ok;
		logic seq_eq;
		logic seq_ge_high;
		logic seq_gt;
		logic pending;
		logic mod_done;
		logic match;
		logic walk_end;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/srarq_mod.sv =====
`default_nettype none

module srarq_mod
	import srarq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SEQ_W-1:0] value,
	output logic                  done,
	output logic [IDX_W-1:0]      rem
);

	if (WIN_POW2) begin : g_mask
		logic [IDX_W-1:0] rem_q;
		logic             done_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				rem_q <= value[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign rem  = rem_q;
	end else begin : g_iter
		localparam int DIG    = 4;
		localparam int STEPS  = SEQ_W / DIG;
		localparam int STEP_W = $clog2(STEPS);

		logic [SEQ_W-1:0]  val_q;
		logic [IDX_W-1:0]  r_q;
		logic [IDX_W-1:0]  r_nxt;
		logic [IDX_W:0]    t;
		logic [STEP_W-1:0] cnt_q;
		logic              busy_q;
		logic              done_q;

		always_comb begin
			r_nxt = r_q;
			t = '0;
			for (int b = 0; b < DIG; b++) begin
				t = {r_nxt, val_q[SEQ_W-1-b]};
				if (t >= (IDX_W+1)'(WINDOW_DEPTH)) begin
					t = t - (IDX_W+1)'(WINDOW_DEPTH);
				end
				r_nxt = t[IDX_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= 1'b0;
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(STEPS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				val_q <= value;
				r_q   <= '0;
			end else if (busy_q) begin
				val_q <= val_q << DIG;
				r_q   <= r_nxt;
			end
		end

		assign done = done_q;
		assign rem  = r_q;
	end

endmodule

`default_nettype wire

// ===== sv/srarq_dp.sv =====
`default_nettype none

module srarq_dp
	import srarq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pkt_t      pkt,
	input  wire ctrl_cmd_t cmd,
	output dp_stat_t       stat,
	output logic           msg_valid,
	input  wire logic      msg_stall,
	output msg_t           msg
);

	pkt_t                    pkt_q;
	logic [SEQ_W-1:0]        expected_q;
	logic [SEQ_W-1:0]        highest_q;
	logic                    pending_q;
	logic [WINDOW_DEPTH-1:0] slot_valid_q;
	slot_t                   slot_mem_q [WINDOW_DEPTH];
	slot_t                   rd_q;
	logic                    rd_valid_q;
	logic [IDX_W-1:0]        w_idx_q;
	logic [CNT_W-1:0]        k_q;
	msg_t                    msg_q;
	logic                    msg_valid_q;
	logic                    mod_done;
	logic [IDX_W-1:0]        mod_rem;
	msg_t                    msg_nxt;

	srarq_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mod_start),
		.value  (pkt_q.seq_num),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_comb begin
		stat.is_eof      = pkt_q.action;
		stat.eof_ok      = (expected_q > highest_q) || (expected_q == '0 && highest_q == '0);
		stat.seq_eq      = (pkt_q.seq_num == expected_q);
		stat.seq_ge_high = (pkt_q.seq_num >= highest_q);
		stat.seq_gt      = (pkt_q.seq_num > expected_q);
		stat.pending     = pending_q;
		stat.mod_done    = mod_done;
		stat.match       = rd_valid_q && (rd_q.seq == expected_q);
		stat.walk_end    = (expected_q == highest_q) || (k_q == CNT_W'(WINDOW_DEPTH));
		stat.out_free    = !msg_valid_q || !msg_stall;
	end

	always_comb begin
		msg_nxt.msg_kind = cmd.kind;
		msg_nxt.last     = cmd.last;
		case (cmd.src)
			SRC_PKT: begin
				msg_nxt.seq_value  = pkt_q.seq_num;
				msg_nxt.out_tag    = pkt_q.payload_tag;
				msg_nxt.out_length = pkt_q.payload_length;
			end
			SRC_SLOT: begin
				msg_nxt.seq_value  = expected_q;
				msg_nxt.out_tag    = rd_q.tag;
				msg_nxt.out_length = rd_q.len;
			end
			SRC_EXP: begin
				msg_nxt.seq_value  = expected_q;
				msg_nxt.out_tag    = '0;
				msg_nxt.out_length = '0;
			end
			default: begin
				msg_nxt.seq_value  = '0;
				msg_nxt.out_tag    = '0;
				msg_nxt.out_length = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q   <= '0;
			highest_q    <= '0;
			pending_q    <= 1'b0;
			slot_valid_q <= '0;
			k_q          <= '0;
			msg_valid_q  <= 1'b0;
		end else begin
			if (cmd.inorder) begin
				highest_q  <= pkt_q.seq_num;
				expected_q <= pkt_q.seq_num + SEQ_W'(1);
			end else if (cmd.step) begin
				expected_q <= expected_q + SEQ_W'(1);
			end
			if (cmd.raise_high && pkt_q.seq_num > highest_q) begin
				highest_q <= pkt_q.seq_num;
			end
			if (cmd.set_pend) begin
				pending_q <= 1'b1;
			end else if (cmd.fin_pend && expected_q == highest_q + SEQ_W'(1)) begin
				pending_q <= 1'b0;
			end
			if (cmd.hold) begin
				slot_valid_q[mod_rem] <= 1'b1;
			end else if (cmd.step) begin
				slot_valid_q[w_idx_q] <= 1'b0;
			end
			if (cmd.walk_start) begin
				k_q <= '0;
			end else if (cmd.step) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				msg_valid_q <= 1'b1;
			end else if (!msg_stall) begin
				msg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pkt_q <= pkt;
		end
		if (cmd.hold) begin
			slot_mem_q[mod_rem] <= '{seq: pkt_q.seq_num, tag: pkt_q.payload_tag,
				len: pkt_q.payload_length};
		end
		if (cmd.rd) begin
			rd_q       <= slot_mem_q[w_idx_q];
			rd_valid_q <= slot_valid_q[w_idx_q];
		end
		if (cmd.hold) begin
			w_idx_q <= mod_rem;
		end else if (cmd.step) begin
			if (w_idx_q == IDX_W'(WINDOW_DEPTH - 1)) begin
				w_idx_q <= '0;
			end else begin
				w_idx_q <= w_idx_q + IDX_W'(1);
			end
		end
		if (cmd.emit) begin
			msg_q <= msg_nxt;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

endmodule

`default_nettype wire

// ===== sv/srarq_ctrl.sv =====
`default_nettype none

module srarq_ctrl
	import srarq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pkt_valid,
	output logic          pkt_stall,
	input  wire dp_stat_t stat,
	output ctrl_cmd_t     cmd
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_DECODE    = 11'b000_0000_0010,
		ST_MODW      = 11'b000_0000_0100,
		ST_HOLD      = 11'b000_0000_1000,
		ST_EMIT_DLV  = 11'b000_0001_0000,
		ST_EMIT_RR   = 11'b000_0010_0000,
		ST_EMIT_SREJ = 11'b000_0100_0000,
		ST_EMIT_EOF  = 11'b000_1000_0000,
		ST_DRAIN_RD  = 11'b001_0000_0000,
		ST_DRAIN_CHK = 11'b010_0000_0000,
		ST_FIN       = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.kind  = KIND_RR;
		cmd.src   = SRC_ZERO;
		case (state_q)
			ST_IDLE: begin
				if (pkt_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.is_eof) begin
					state_nxt = stat.eof_ok ? ST_EMIT_EOF : ST_IDLE;
				end else if (stat.seq_eq && stat.seq_ge_high) begin
					state_nxt = ST_EMIT_DLV;
				end else if (stat.seq_eq || stat.seq_gt) begin
					cmd.mod_start = 1'b1;
					state_nxt     = ST_MODW;
				end else begin
					state_nxt = ST_EMIT_RR;
				end
			end
			ST_MODW: begin
				if (stat.mod_done) begin
					state_nxt = ST_HOLD;
				end
			end
			ST_HOLD: begin
				cmd.hold = 1'b1;
				if (stat.seq_eq) begin
					cmd.walk_start = 1'b1;
					state_nxt      = ST_DRAIN_RD;
				end else begin
					cmd.raise_high = 1'b1;
					if (!stat.pending) begin
						cmd.set_pend = 1'b1;
						state_nxt    = ST_EMIT_SREJ;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_EMIT_DLV: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = KIND_DELIVER;
					cmd.src     = SRC_PKT;
					cmd.inorder = 1'b1;
					state_nxt   = ST_EMIT_RR;
				end
			end
			ST_EMIT_RR: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = KIND_RR;
					cmd.src   = SRC_EXP;
					cmd.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_EMIT_SREJ: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = KIND_SREJ;
					cmd.src   = SRC_EXP;
					cmd.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_EMIT_EOF: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = KIND_EOFACK;
					cmd.src   = SRC_ZERO;
					cmd.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_DRAIN_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_DRAIN_CHK;
			end
			ST_DRAIN_CHK: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.match) begin
						cmd.kind  = KIND_DELIVER;
						cmd.src   = SRC_SLOT;
						cmd.step  = 1'b1;
						state_nxt = stat.walk_end ? ST_FIN : ST_DRAIN_RD;
					end else begin
						cmd.kind     = KIND_SREJ;
						cmd.src      = SRC_EXP;
						cmd.set_pend = 1'b1;
						state_nxt    = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				cmd.fin_pend = 1'b1;
				state_nxt    = ST_EMIT_RR;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign pkt_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/selective_repeat_arq_receiver.sv =====
// Receiver of a selective-repeat ARQ link. Each beat on the pkt channel is one
// packet: data with a sequence number and a payload descriptor, or end of file.
// Each beat on the msg channel is one response: a payload to deliver, an RR,
// an SREJ or an EOF ack; the last response of a packet carries last.
// Packets are taken one at a time: pkt_stall is high from the state after the
// one that takes a packet until the controller is back in idle, after its last
// response is loaded into the output register, or sooner if it draws none.
// An in-order packet passes decode, a deliver response and an RR response
// before the next accept. A packet that goes into the reorder window also
// passes a sequence-modulo unit (a register when the window depth is a power
// of two, a digit-serial reduction otherwise), and draining the window reads
// each held packet through the registered read of the slot memory.
// When msg_stall is high the pending response holds in the output register and
// the controller waits; no response is dropped or reordered.
// Reset clears the expected and highest numbers, the SREJ flag, every slot's
// valid bit and the output valid flag, so the block needs no clearing pass.
`default_nettype none

module selective_repeat_arq_receiver
	import srarq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pkt_valid,
	output logic      pkt_stall,
	input  wire pkt_t pkt,
	output logic      msg_valid,
	input  wire logic msg_stall,
	output msg_t      msg
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	srarq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	srarq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.cmd       (cmd),
		.stat      (stat),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg)
	);

endmodule

`default_nettype wire
